// ===== design/ecpp_pkg.sv =====
// ----------------------------------------------------------------------------
// ecpp_pkg: shared constants for the projective point unit
// Field and scalar widths, mode codes and register indexes.
// ----------------------------------------------------------------------------
package ecpp_pkg;
   localparam int FIELD_BITS_DEF  = 63;
   localparam int SCALAR_BITS_DEF = 64;
   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_DBL = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic CSR_MODULUS = 1'b0;
   localparam logic CSR_CURVE_A = 1'b1;
endpackage

// ===== design/ecpp_mont.sv =====
// ----------------------------------------------------------------------------
// ecpp_mont: bit-serial modular arithmetic unit
// Computes a*b mod p one multiplier bit per cycle (double-and-add). Operand a
// must already be below p; b may be any FB-bit value, so 1*b reduces b mod p.
// ----------------------------------------------------------------------------
module ecpp_mont import ecpp_pkg::*; #(
   parameter int FB = FIELD_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [FB-1:0] a,
   input  logic [FB-1:0] b,
   input  logic [FB-1:0] p,
   output logic          done,
   output logic [FB-1:0] r
);
   localparam int CW = $clog2(FB + 1);
   logic [FB-1:0] acc_ff, acc_in, b_ff, a_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic [FB:0]   dbl, dsub, ad, asub;
   logic [FB-1:0] d1;

   // The accumulator stays below p and a is below p, so one conditional
   // subtract after the double and one after the add keep it reduced.
   always_comb begin
      dbl  = {acc_ff, 1'b0};
      dsub = dbl - {1'b0, p};
      d1   = dsub[FB] ? dbl[FB-1:0] : dsub[FB-1:0];
      ad   = {1'b0, d1} + {1'b0, a_ff};
      asub = ad - {1'b0, p};
      acc_in = d1;
      if (b_ff[FB-1]) begin
         acc_in = asub[FB] ? ad[FB-1:0] : asub[FB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(FB);
            acc_ff  <= '0;
            a_ff    <= a;
            b_ff    <= b;
         end else if (busy_ff) begin
            acc_ff <= acc_in;
            b_ff   <= {b_ff[FB-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
   end
   assign r = acc_ff;
endmodule

// ===== design/ec_projective_point_unit.sv =====
// ----------------------------------------------------------------------------
// ec_projective_point_unit: projective point add, double and scalar multiply
// Every modular multiply runs on the single bit-serial multiplier; entry
// reduction takes 7 multiplies, a double 19 and an add 16, so one
// double-and-add round is 35 multiplies. One word at a time.
// Reset (synchronous, active high) returns modulus to 7 and curve_a to 0.
// ----------------------------------------------------------------------------
module ec_projective_point_unit import ecpp_pkg::*; #(
   parameter int FIELD_BITS  = FIELD_BITS_DEF,
   parameter int SCALAR_BITS = SCALAR_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_mode,
   input  logic [FIELD_BITS-1:0]  req_x1,
   input  logic [FIELD_BITS-1:0]  req_y1,
   input  logic [FIELD_BITS-1:0]  req_z1,
   input  logic                   req_inf1,
   input  logic [FIELD_BITS-1:0]  req_x2,
   input  logic [FIELD_BITS-1:0]  req_y2,
   input  logic [FIELD_BITS-1:0]  req_z2,
   input  logic                   req_inf2,
   input  logic [SCALAR_BITS-1:0] req_scalar,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [FIELD_BITS-1:0]  rsp_rx,
   output logic [FIELD_BITS-1:0]  rsp_ry,
   output logic [FIELD_BITS-1:0]  rsp_rz,
   output logic                   rsp_rinf,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [FIELD_BITS-1:0]  csr_wdata
);
   localparam int FB = FIELD_BITS;
   localparam int SB = SCALAR_BITS;
   localparam int IW = $clog2(SB);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE = 4'd0, ST_RED = 4'd1, ST_DISP = 4'd2,
      ST_DBL = 4'd3, ST_ADD = 4'd4, ST_NEXT = 4'd5, ST_FIN = 4'd6,
      ST_OUT = 4'd7, ST_MUL = 4'd8;

   logic [FB-1:0] mod_ff, ca_ff, pm;
   logic [3:0]    st_ff, ret_ff;
   logic [4:0]    step_ff;
   logic [1:0]    mode_ff;
   logic [FB-1:0] ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff, am_ff;
   logic          ainf_ff, binf_ff, neg_ff, rinf_ff;
   logic [FB-1:0] px_ff, py_ff, pz_ff;   // base point for scalar mode
   logic [SB-1:0] mag_ff;
   logic [IW-1:0] bit_ff;
   logic          scal_ff;
   logic [FB-1:0] t_ff [0:11];           // scratch: fixed-use temporaries
   logic          mstart;
   logic [FB-1:0] ma, mb;
   logic          mdone;
   logic [FB-1:0] mr;
   logic [FB-1:0] red_src [0:6];

   assign pm = (mod_ff == '0) ? FB'(1) : mod_ff;

   ecpp_mont #(.FB(FB)) u_mul (
      .clock(clock), .reset(reset), .start(mstart), .a(ma), .b(mb),
      .p(pm), .done(mdone), .r(mr)
   );

   function automatic logic [FB-1:0] fadd(input logic [FB-1:0] x, y, p);
      logic [FB:0] s, d;
      s = {1'b0, x} + {1'b0, y};
      d = s - {1'b0, p};
      return d[FB] ? s[FB-1:0] : d[FB-1:0];
   endfunction
   function automatic logic [FB-1:0] fsub(input logic [FB-1:0] x, y, p);
      return (x >= y) ? x - y : FB'({1'b0, x} + {1'b0, p} - {1'b0, y});
   endfunction

   // Small constants reduced mod p by the field adder.
   logic [FB-1:0] k1, k2, k3, k4, k8;
   always_comb begin
      k1 = (pm == FB'(1)) ? '0 : FB'(1);
      k2 = fadd(k1, k1, pm);
      k3 = fadd(k2, k1, pm);
      k4 = fadd(k2, k2, pm);
      k8 = fadd(k4, k4, pm);
   end

   // Reduction on entry is a multiply by one: 1*x mod p, with the raw value
   // as the serial multiplier so that it may be any width below 2^FB.
   always_comb begin
      red_src[0] = ax_ff; red_src[1] = ay_ff; red_src[2] = az_ff;
      red_src[3] = bx_ff; red_src[4] = by_ff; red_src[5] = bz_ff;
      red_src[6] = am_ff;
   end

   // Microcode operand selection: each step names two operands.
   // T indexes: 0 w,1 s,2 bb,3 h,4 tmp,5 tmp2,6 u1,7 u2,8 v1,9 v2,10 ww,11 v2sq
   always_comb begin
      ma = '0; mb = '0;
      if (st_ff == ST_RED) begin
         ma = k1;
         mb = red_src[step_ff[2:0] == 3'd7 ? 3'd6 : step_ff[2:0]];
      end else if (st_ff == ST_DBL) begin
         case (step_ff)
            5'd0:  begin ma = ax_ff;    mb = ax_ff;    end
            5'd1:  begin ma = t_ff[4];  mb = k3;       end
            5'd2:  begin ma = az_ff;    mb = az_ff;    end
            5'd3:  begin ma = t_ff[5];  mb = am_ff;    end
            5'd4:  begin ma = ay_ff;    mb = az_ff;    end
            5'd5:  begin ma = ax_ff;    mb = ay_ff;    end
            5'd6:  begin ma = t_ff[4];  mb = t_ff[1];  end
            5'd7:  begin ma = t_ff[0];  mb = t_ff[0];  end
            5'd8:  begin ma = t_ff[2];  mb = k8;       end
            5'd9:  begin ma = t_ff[3];  mb = t_ff[1];  end
            5'd10: begin ma = t_ff[4];  mb = k2;       end
            5'd11: begin ma = ay_ff;    mb = ay_ff;    end
            5'd12: begin ma = t_ff[1];  mb = t_ff[1];  end
            5'd13: begin ma = t_ff[4];  mb = t_ff[5];  end
            5'd14: begin ma = t_ff[4];  mb = k8;       end
            5'd15: begin ma = t_ff[2];  mb = k4;       end
            5'd16: begin ma = t_ff[0];  mb = t_ff[6];  end
            5'd17: begin ma = t_ff[5];  mb = t_ff[1];  end
            5'd18: begin ma = t_ff[4];  mb = k8;       end
            default: begin ma = '0; mb = '0; end
         endcase
      end else if (st_ff == ST_ADD) begin
         case (step_ff)
            5'd0:  begin ma = by_ff;    mb = az_ff;    end
            5'd1:  begin ma = ay_ff;    mb = bz_ff;    end
            5'd2:  begin ma = bx_ff;    mb = az_ff;    end
            5'd3:  begin ma = ax_ff;    mb = bz_ff;    end
            5'd4:  begin ma = az_ff;    mb = bz_ff;    end
            5'd5:  begin ma = t_ff[8];  mb = t_ff[8];  end
            5'd6:  begin ma = t_ff[11]; mb = t_ff[8];  end
            5'd7:  begin ma = t_ff[6];  mb = t_ff[6];  end
            5'd8:  begin ma = t_ff[4];  mb = t_ff[10]; end
            5'd9:  begin ma = t_ff[11]; mb = k2;       end
            5'd10: begin ma = t_ff[4];  mb = t_ff[9];  end
            5'd11: begin ma = t_ff[8];  mb = t_ff[3];  end
            5'd12: begin ma = t_ff[11]; mb = t_ff[9];  end
            5'd13: begin ma = t_ff[6];  mb = t_ff[4];  end
            5'd14: begin ma = t_ff[5];  mb = t_ff[7];  end
            5'd15: begin ma = t_ff[5];  mb = t_ff[10]; end
            default: begin ma = '0; mb = '0; end
         endcase
      end
   end

   logic [IW:0] top;
   always_comb begin
      top = '0;
      for (int i = 0; i < SB; i++) begin
         if (mag_ff[i]) top = (IW+1)'(i);
      end
   end

   // A double of an infinite point finishes at once, so no multiply is
   // started for it.
   logic busy_mul_ff;
   assign mstart = (st_ff == ST_RED || st_ff == ST_ADD ||
                    (st_ff == ST_DBL && !ainf_ff && az_ff != '0)) && !busy_mul_ff;
   assign req_ready = (st_ff == ST_IDLE) && !rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff      <= FB'(7);
         ca_ff       <= '0;
         st_ff       <= ST_IDLE;
         rsp_valid   <= 1'b0;
         busy_mul_ff <= 1'b0;
         step_ff     <= '0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_MODULUS) mod_ff <= csr_wdata;
            else ca_ff <= csr_wdata;
         end
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         if (mstart) busy_mul_ff <= 1'b1;
         unique case (st_ff)
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  mode_ff <= req_mode;
                  ax_ff <= req_x1; ay_ff <= req_y1; az_ff <= req_z1;
                  bx_ff <= req_x2; by_ff <= req_y2; bz_ff <= req_z2;
                  ainf_ff <= req_inf1; binf_ff <= req_inf2;
                  am_ff <= ca_ff;
                  neg_ff <= req_scalar[SB-1];
                  mag_ff <= req_scalar[SB-1] ? (~req_scalar + 1'b1) : req_scalar;
                  step_ff <= '0;
                  st_ff <= ST_RED;
               end
            end
            ST_RED: begin
               if (mdone) begin
                  busy_mul_ff <= 1'b0;
                  case (step_ff[2:0])
                     3'd0: ax_ff <= mr; 3'd1: ay_ff <= mr; 3'd2: az_ff <= mr;
                     3'd3: bx_ff <= mr; 3'd4: by_ff <= mr; 3'd5: bz_ff <= mr;
                     default: am_ff <= mr;
                  endcase
                  if (step_ff == 5'd6) st_ff <= ST_DISP;
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_DISP: begin
               step_ff <= '0;
               scal_ff <= 1'b0;
               rinf_ff <= 1'b0;
               case (mode_ff)
                  MODE_ADD: begin
                     if (ainf_ff || az_ff == '0) begin
                        rinf_ff <= binf_ff;
                        ax_ff <= bx_ff; ay_ff <= by_ff; az_ff <= bz_ff;
                        st_ff <= ST_OUT;
                     end else if (binf_ff || bz_ff == '0) begin
                        st_ff <= ST_OUT;
                     end else begin
                        st_ff <= ST_ADD;
                     end
                  end
                  MODE_DBL: st_ff <= ST_DBL;
                  MODE_MUL: begin
                     if (mag_ff == '0 || ainf_ff) begin
                        rinf_ff <= 1'b1;
                        st_ff <= ST_OUT;
                     end else begin
                        scal_ff <= 1'b1;
                        px_ff <= ax_ff; py_ff <= ay_ff; pz_ff <= az_ff;
                        bit_ff <= IW'(top);
                        st_ff <= ST_NEXT;
                     end
                  end
                  default: begin
                     rinf_ff <= 1'b1;
                     st_ff <= ST_OUT;
                  end
               endcase
            end
            ST_DBL: begin
               if (ainf_ff || az_ff == '0) begin
                  rinf_ff <= 1'b1;
                  ainf_ff <= 1'b1;
                  st_ff <= ret_ff;
                  if (!scal_ff) st_ff <= ST_OUT;
               end else if (mdone) begin
                  busy_mul_ff <= 1'b0;
                  step_ff <= step_ff + 1'b1;
                  case (step_ff)
                     5'd0:  t_ff[4] <= mr;
                     5'd1:  t_ff[0] <= mr;
                     5'd2:  t_ff[5] <= mr;
                     5'd3:  t_ff[0] <= fadd(t_ff[0], mr, pm);
                     5'd4:  t_ff[1] <= mr;
                     5'd5:  t_ff[4] <= mr;
                     5'd6:  t_ff[2] <= mr;
                     5'd7:  t_ff[3] <= mr;
                     5'd8:  t_ff[3] <= fsub(t_ff[3], mr, pm);
                     5'd9:  t_ff[4] <= mr;
                     5'd10: t_ff[7] <= mr;
                     5'd11: t_ff[4] <= mr;
                     5'd12: t_ff[5] <= mr;
                     5'd13: t_ff[4] <= mr;
                     5'd14: t_ff[8] <= mr;
                     5'd15: t_ff[6] <= fsub(mr, t_ff[3], pm);
                     5'd16: t_ff[9] <= fsub(mr, t_ff[8], pm);
                     5'd17: t_ff[4] <= mr;
                     default: begin
                        ax_ff <= t_ff[7]; ay_ff <= t_ff[9]; az_ff <= mr;
                        rinf_ff <= 1'b0;
                        step_ff <= '0;
                        st_ff <= scal_ff ? ret_ff : ST_OUT;
                     end
                  endcase
               end
            end
            ST_ADD: begin
               if (mdone) begin
                  busy_mul_ff <= 1'b0;
                  step_ff <= step_ff + 1'b1;
                  case (step_ff)
                     5'd0:  t_ff[6] <= mr;
                     5'd1:  t_ff[7] <= mr;
                     5'd2:  t_ff[8] <= mr;
                     5'd3: begin
                        t_ff[9] <= mr;
                        if (t_ff[8] == mr) begin
                           step_ff <= '0;
                           if (t_ff[6] == t_ff[7]) begin
                              // The double replaces the add of this round.
                              ret_ff <= ST_NEXT;
                              st_ff  <= ST_DBL;
                           end else begin
                              rinf_ff <= 1'b1; ainf_ff <= 1'b1;
                              st_ff <= scal_ff ? ST_FIN : ST_OUT;
                           end
                        end else begin
                           t_ff[6] <= fsub(t_ff[6], t_ff[7], pm);
                           t_ff[8] <= fsub(t_ff[8], mr, pm);
                        end
                     end
                     5'd4:  t_ff[10] <= mr;
                     5'd5:  t_ff[11] <= mr;
                     5'd6:  t_ff[5] <= mr;
                     5'd7:  t_ff[4] <= mr;
                     5'd8:  t_ff[3] <= fsub(mr, t_ff[5], pm);
                     5'd9:  t_ff[4] <= mr;
                     5'd10: t_ff[3] <= fsub(t_ff[3], mr, pm);
                     5'd11: t_ff[0] <= mr;
                     5'd12: t_ff[4] <= fsub(mr, t_ff[3], pm);
                     5'd13: t_ff[1] <= mr;
                     5'd14: t_ff[1] <= fsub(t_ff[1], mr, pm);
                     default: begin
                        ax_ff <= t_ff[0]; ay_ff <= t_ff[1]; az_ff <= mr;
                        rinf_ff <= 1'b0; ainf_ff <= 1'b0;
                        step_ff <= '0;
                        st_ff <= scal_ff ? ST_FIN : ST_OUT;
                     end
                  endcase
               end
            end
            ST_NEXT: begin
               // One double-and-add round per scalar bit below the top one.
               step_ff <= '0;
               if (bit_ff == '0) begin
                  st_ff <= ST_MUL;
               end else begin
                  bit_ff <= bit_ff - 1'b1;
                  ret_ff <= ST_FIN;
                  st_ff  <= ST_DBL;
               end
            end
            ST_FIN: begin
               // After the double, add the base point if this bit is set.
               step_ff <= '0;
               if (ret_ff == ST_FIN && mag_ff[bit_ff]) begin
                  ret_ff <= ST_NEXT;
                  if (ainf_ff || az_ff == '0) begin
                     ax_ff <= px_ff; ay_ff <= py_ff; az_ff <= pz_ff;
                     ainf_ff <= 1'b0; rinf_ff <= 1'b0;
                     st_ff <= ST_NEXT;
                  end else begin
                     bx_ff <= px_ff; by_ff <= py_ff; bz_ff <= pz_ff;
                     st_ff <= (pz_ff == '0) ? ST_NEXT : ST_ADD;
                  end
               end else begin
                  ret_ff <= ST_FIN;
                  st_ff <= ST_NEXT;
               end
            end
            ST_MUL: begin
               if (neg_ff && !rinf_ff) ay_ff <= fsub('0, ay_ff, pm);
               st_ff <= ST_OUT;
            end
            default: begin
               rsp_valid <= 1'b1;
               rsp_rinf  <= rinf_ff;
               rsp_rx <= rinf_ff ? '0 : ax_ff;
               rsp_ry <= rinf_ff ? '0 : ay_ff;
               rsp_rz <= rinf_ff ? '0 : az_ff;
               st_ff  <= ST_IDLE;
            end
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rx))
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rinf |-> rsp_rx == '0 && rsp_rz == '0)
      else $error("infinite result with nonzero coordinates");
   assert property (@(posedge clock) disable iff (reset)
      mdone |-> st_ff == ST_RED || st_ff == ST_DBL || st_ff == ST_ADD)
      else $error("multiplier finished outside a compute state");
endmodule

// ===== tb/ec_projective_point_unit_tb.sv =====
// ----------------------------------------------------------------------------
// ec_projective_point_unit_tb: self-checking bench for the point unit
// Drives add, double, scalar multiply and unused-mode words through the
// request channel and checks the response words in order against typed-in
// points or an independent point model. Both channels idle at random, and the
// field modulus and curve coefficient are changed between phases while idle.
// ----------------------------------------------------------------------------
module ec_projective_point_unit_tb;
   import ecpp_pkg::*;

   // Mode 3 has no operation behind it; the unit must answer with infinity.
   localparam logic [1:0] MODE_NONE = 2'd3;
   localparam int unsigned RUN_LIMIT = 30000000;
   localparam logic [62:0] BIG_PRIME = 63'h7fff_ffff_ffff_ffe7;

   typedef struct {
      logic [62:0] x, y, z;
      logic        inf;
   } point_type;

   typedef struct {
      logic [1:0]  mode;
      point_type   p1, p2;
      logic [63:0] scalar;
      logic        known;   // the expected point below is typed in
      point_type   want;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, rsp_ready = 1'b0, csr_we = 1'b0, csr_index = 1'b0;
   logic [1:0]  req_mode = '0;
   logic [62:0] req_x1 = '0, req_y1 = '0, req_z1 = '0;
   logic [62:0] req_x2 = '0, req_y2 = '0, req_z2 = '0;
   logic        req_inf1 = 1'b0, req_inf2 = 1'b0;
   logic [63:0] req_scalar = '0;
   logic [62:0] csr_wdata = '0;
   logic        req_ready, rsp_valid, rsp_rinf;
   logic [62:0] rsp_rx, rsp_ry, rsp_rz;

   ec_projective_point_unit u_dut (.*);

   // Shadow copies of the two field registers.
   logic [63:0] field_p = 64'd7;
   logic [63:0] coef_a = 64'd0;

   point_type   pending_points[$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Field and point arithmetic. All operands are kept below the working
   // modulus, so plain modular products are exact.
   // ------------------------------------------------------------------------
   function automatic logic [63:0] f_mul(logic [63:0] a, logic [63:0] b, logic [63:0] p);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return 64'(prod % {64'd0, p});
   endfunction

   function automatic logic [63:0] f_add(logic [63:0] a, logic [63:0] b, logic [63:0] p);
      return (a + b) % p;
   endfunction

   function automatic logic [63:0] f_sub(logic [63:0] a, logic [63:0] b, logic [63:0] p);
      return (a >= b) ? a - b : a + p - b;
   endfunction

   function automatic point_type at_infinity();
      point_type r;
      r.x = '0; r.y = '0; r.z = '0; r.inf = 1'b1;
      return r;
   endfunction

   function automatic point_type point_double(point_type a, logic [63:0] p, logic [63:0] ca);
      point_type r;
      logic [63:0] w, s, bb, h, t, ss;
      if (a.inf || a.z == 0) return at_infinity();
      w  = f_add(f_mul(f_mul(a.x, a.x, p), 3 % p, p), f_mul(f_mul(a.z, a.z, p), ca, p), p);
      s  = f_mul(a.y, a.z, p);
      ss = f_mul(s, s, p);
      bb = f_mul(f_mul(a.x, a.y, p), s, p);
      h  = f_sub(f_mul(w, w, p), f_mul(bb, 8 % p, p), p);
      t  = f_mul(f_mul(f_mul(a.y, a.y, p), ss, p), 8 % p, p);
      r.x = 63'(f_mul(f_mul(h, s, p), 2 % p, p));
      r.y = 63'(f_sub(f_mul(w, f_sub(f_mul(bb, 4 % p, p), h, p), p), t, p));
      r.z = 63'(f_mul(f_mul(ss, s, p), 8 % p, p));
      r.inf = 1'b0;
      return r;
   endfunction

   function automatic point_type point_add(point_type a, point_type b, logic [63:0] p,
                                           logic [63:0] ca);
      point_type r;
      logic [63:0] u1, u2, v1, v2, u, v, w, vsq, vcube, big;
      if (a.inf || a.z == 0) return b;
      if (b.inf || b.z == 0) begin
         r = a;
         r.inf = 1'b0;
         return r;
      end
      u1 = f_mul(b.y, a.z, p);
      u2 = f_mul(a.y, b.z, p);
      v1 = f_mul(b.x, a.z, p);
      v2 = f_mul(a.x, b.z, p);
      if (v1 == v2) begin
         if (u1 == u2) return point_double(a, p, ca);
         return at_infinity();
      end
      u = f_sub(u1, u2, p);
      v = f_sub(v1, v2, p);
      w = f_mul(a.z, b.z, p);
      vsq = f_mul(v, v, p);
      vcube = f_mul(vsq, v, p);
      big = f_sub(f_sub(f_mul(f_mul(u, u, p), w, p), vcube, p),
                  f_mul(f_mul(vsq, 2 % p, p), v2, p), p);
      r.x = 63'(f_mul(v, big, p));
      r.y = 63'(f_sub(f_mul(u, f_sub(f_mul(vsq, v2, p), big, p), p), f_mul(vcube, u2, p), p));
      r.z = 63'(f_mul(vcube, w, p));
      r.inf = 1'b0;
      return r;
   endfunction

   // Full prediction of one request word under the current register values.
   function automatic point_type predict_point(stim_type s);
      logic [63:0] p, ca, mag;
      point_type a, b, acc;
      int top;
      p  = (field_p == 0) ? 64'd1 : field_p;
      ca = coef_a % p;
      a.x = 63'(s.p1.x % p); a.y = 63'(s.p1.y % p); a.z = 63'(s.p1.z % p);
      a.inf = s.p1.inf;
      b.x = 63'(s.p2.x % p); b.y = 63'(s.p2.y % p); b.z = 63'(s.p2.z % p);
      b.inf = s.p2.inf;
      case (s.mode)
         MODE_ADD: acc = point_add(a, b, p, ca);
         MODE_DBL: acc = point_double(a, p, ca);
         MODE_MUL: begin
            mag = s.scalar[63] ? -s.scalar : s.scalar;
            if (mag == 0 || a.inf) return at_infinity();
            top = 63;
            while (!mag[top]) top--;
            acc = a;
            for (int i = top - 1; i >= 0; i--) begin
               acc = point_double(acc, p, ca);
               if (mag[i]) acc = point_add(acc, a, p, ca);
            end
            if (s.scalar[63] && !acc.inf) acc.y = 63'(f_sub(0, acc.y, p));
         end
         default: return at_infinity();
      endcase
      if (acc.inf) return at_infinity();
      return acc;
   endfunction

   // ------------------------------------------------------------------------
   // Request side. Inputs change on the falling edge; acceptance is seen on
   // the rising edge. Valid stays up between back-to-back words.
   // ------------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 120);
   endfunction

   task automatic send_word(stim_type s);
      int unsigned gap;
      req_valid = 1'b1;
      req_mode = s.mode;
      req_x1 = s.p1.x; req_y1 = s.p1.y; req_z1 = s.p1.z; req_inf1 = s.p1.inf;
      req_x2 = s.p2.x; req_y2 = s.p2.y; req_z2 = s.p2.z; req_inf2 = s.p2.inf;
      req_scalar = s.scalar;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      pending_points.push_back(s.known ? s.want : predict_point(s));
      @(negedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Lets every outstanding result come back.
   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic index, logic [62:0] value);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (index == CSR_MODULUS) field_p = {1'b0, value};
      else coef_a = {1'b0, value};
   endtask

   // ------------------------------------------------------------------------
   // Random words. Coordinates are mostly below the modulus, sometimes any
   // 63-bit value so that reduction on entry is exercised. Scalars are kept
   // short because each bit costs a double and an add on the serial multiplier.
   // ------------------------------------------------------------------------
   function automatic logic [62:0] rand_coord();
      logic [62:0] v;
      logic [63:0] p;
      p = (field_p == 0) ? 64'd1 : field_p;
      v = 63'({$urandom, $urandom});
      case ($urandom_range(0, 9))
         0: return v;
         1: return 63'($urandom_range(0, 3));
         default: return 63'({1'b0, v} % p);
      endcase
   endfunction

   function automatic point_type rand_point();
      point_type r;
      r.x = rand_coord(); r.y = rand_coord(); r.z = rand_coord();
      if ($urandom_range(0, 9) == 0) r.z = '0;
      r.inf = ($urandom_range(0, 11) == 0);
      return r;
   endfunction

   function automatic stim_type rand_stim();
      stim_type s;
      logic [63:0] p, lam;
      int unsigned pick, nbits;
      p = (field_p == 0) ? 64'd1 : field_p;
      s.known = 1'b0;
      s.want = at_infinity();
      s.p1 = rand_point();
      s.p2 = rand_point();
      s.scalar = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         s.mode = MODE_ADD;
         // Scaled copies of the first point give the equal and opposite cases.
         if ($urandom_range(0, 2) == 0) begin
            lam = {$urandom, $urandom} % p;
            s.p1.x = 63'(s.p1.x % p); s.p1.y = 63'(s.p1.y % p); s.p1.z = 63'(s.p1.z % p);
            s.p2.x = 63'(f_mul(s.p1.x, lam, p));
            s.p2.y = 63'(f_mul(s.p1.y, lam, p));
            s.p2.z = 63'(f_mul(s.p1.z, lam, p));
            if ($urandom_range(0, 1)) s.p2.y = 63'(f_sub(0, s.p2.y, p));
            s.p1.inf = 1'b0;
            s.p2.inf = 1'b0;
         end
      end else if (pick < 65) begin
         s.mode = MODE_DBL;
      end else if (pick < 97) begin
         s.mode = MODE_MUL;
         nbits = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
         s.scalar = {$urandom, $urandom} & ((64'd1 << nbits) - 1);
         if ($urandom_range(0, 1)) s.scalar = -s.scalar;
      end else begin
         s.mode = MODE_NONE;
      end
      return s;
   endfunction

   // ------------------------------------------------------------------------
   // Directed words under the reset registers: modulus 7, curve_a 0.
   // ------------------------------------------------------------------------
   function automatic point_type pt(logic [62:0] x, logic [62:0] y, logic [62:0] z,
                                    logic inf);
      point_type r;
      r.x = x; r.y = y; r.z = z; r.inf = inf;
      return r;
   endfunction

   function automatic stim_type row(logic [1:0] mode, point_type a, point_type b,
                                    logic [63:0] k, logic known, point_type want);
      stim_type s;
      s.mode = mode; s.p1 = a; s.p2 = b; s.scalar = k; s.known = known; s.want = want;
      return s;
   endfunction

   stim_type directed[$];

   initial begin
      point_type inf_pt, ones, zero_pt, g;
      inf_pt = at_infinity();
      ones = pt('1, '1, '1, 1'b0);
      zero_pt = pt('0, '0, '0, 1'b0);
      g = pt(63'd3, 63'd2, 63'd1, 1'b0);
      directed = {
         row(MODE_NONE, g, g, 64'd5, 1'b1, inf_pt),
         row(MODE_DBL, pt(3, 2, 1, 1'b1), g, 0, 1'b1, inf_pt),
         row(MODE_DBL, pt(3, 2, 0, 1'b0), g, 0, 1'b1, inf_pt),
         row(MODE_MUL, g, g, 64'd0, 1'b1, inf_pt),
         row(MODE_MUL, pt(3, 2, 1, 1'b1), g, 64'd3, 1'b1, inf_pt),
         // A magnitude of one hands the point back even with Z of zero.
         row(MODE_MUL, pt(1, 2, 0, 1'b0), g, 64'd1, 1'b1, pt(1, 2, 0, 1'b0)),
         row(MODE_MUL, pt(1, 2, 0, 1'b0), g, '1, 1'b1, pt(1, 5, 0, 1'b0)),
         // An infinite first operand returns the second one with its flag.
         row(MODE_ADD, pt(1, 1, 1, 1'b1), pt(3, 4, 1, 1'b0), 0, 1'b1, pt(3, 4, 1, 1'b0)),
         row(MODE_ADD, pt(1, 1, 0, 1'b0), pt(5, 6, 2, 1'b1), 0, 1'b1, inf_pt),
         row(MODE_ADD, pt(3, 4, 1, 1'b0), pt(1, 1, 1, 1'b1), 0, 1'b1, pt(3, 4, 1, 1'b0)),
         row(MODE_ADD, pt(3, 4, 1, 1'b0), pt(1, 1, 0, 1'b0), 0, 1'b1, pt(3, 4, 1, 1'b0)),
         // Opposite points add to infinity; equal points fall back to doubling.
         row(MODE_ADD, pt(3, 2, 1, 1'b0), pt(3, 5, 1, 1'b0), 0, 1'b1, inf_pt),
         row(MODE_ADD, pt(3, 2, 1, 1'b0), pt(6, 4, 2, 1'b0), 0, 1'b0, inf_pt),
         row(MODE_ADD, g, pt(5, 1, 1, 1'b0), 0, 1'b0, inf_pt),
         row(MODE_ADD, ones, zero_pt, 0, 1'b0, inf_pt),
         row(MODE_DBL, ones, zero_pt, 0, 1'b0, inf_pt),
         row(MODE_DBL, g, g, 0, 1'b0, inf_pt),
         row(MODE_MUL, g, g, 64'd2, 1'b0, inf_pt),
         row(MODE_MUL, g, g, -64'sd6, 1'b0, inf_pt),
         // Scalar extremes: most negative is used as 2^63 exactly.
         row(MODE_MUL, g, g, 64'h8000_0000_0000_0000, 1'b0, inf_pt),
         row(MODE_MUL, ones, g, 64'h7fff_ffff_ffff_ffff, 1'b0, inf_pt)
      };
   end

   // ------------------------------------------------------------------------
   // Response side: random back-pressure, stretches of none, and checking.
   // ------------------------------------------------------------------------
   initial begin
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            rsp_ready = 1'b1;
            repeat ($urandom_range(50, 400)) @(negedge clock);
         end else begin
            rsp_ready = ($urandom_range(0, 2) != 0);
            repeat ((pick_gap() % 60) + 1) @(negedge clock);
         end
      end
   end

   task automatic report_mismatch(string what, logic [62:0] got, logic [62:0] want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      point_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            $display("unexpected result word at cycle %0d", cycle_count);
            error_count++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_rx !== want.x) report_mismatch("rx", rsp_rx, want.x);
            if (rsp_ry !== want.y) report_mismatch("ry", rsp_ry, want.y);
            if (rsp_rz !== want.z) report_mismatch("rz", rsp_rz, want.z);
            if (rsp_rinf !== want.inf) begin
               report_mismatch("rinf", 63'(rsp_rinf), 63'(want.inf));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence: reset, directed words, then random phases, each with its
   // own register setting written while the unit is idle.
   // ------------------------------------------------------------------------
   initial begin
      repeat (8) @(negedge clock);
      reset = 1'b0;
      repeat (2) @(negedge clock);
      foreach (directed[i]) send_word(directed[i]);
      drain_results();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_MODULUS, 63'd5);
               write_reg(CSR_CURVE_A, 63'd4);
            end
            1: begin
               write_reg(CSR_MODULUS, BIG_PRIME);
               write_reg(CSR_CURVE_A, BIG_PRIME - 1);
            end
            2: begin
               write_reg(CSR_MODULUS, 63'd1000003);
               write_reg(CSR_CURVE_A, 63'($urandom_range(0, 1000002)));
            end
            3: begin
               // Out of range on purpose: curve_a above the modulus.
               write_reg(CSR_MODULUS, 63'd101);
               write_reg(CSR_CURVE_A, '1);
            end
            default: begin
               write_reg(CSR_MODULUS, BIG_PRIME);
               write_reg(CSR_CURVE_A, 63'({$urandom, $urandom} % BIG_PRIME));
            end
         endcase
         for (int n = 0; n < 16; n++) send_word(rand_stim());
         drain_results();
      end

      repeat (200) @(negedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
